### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### sv/tlss_pkg.sv
// ----------------------------------------------------------------------------
// tlss_pkg
// Field widths, operation codes and shared helpers of the two-lane loader.
// ----------------------------------------------------------------------------
package tlss_pkg;

  localparam int OP_W   = 2;
  localparam int LEN_W  = 14;
  localparam int IDX_W  = 9;
  localparam int CNT_W  = 9;
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_FINAL = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  // Control of the double-buffered reachability store.
  typedef struct packed {
    logic wr_en;
    logic sel;
    logic fresh;
  } reach_ctl_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (v[b]) begin
        pos = BIT_W'(b);
      end
    end
    return pos;
  endfunction

endpackage

### sv/tlss_in_if.sv
// ----------------------------------------------------------------------------
// tlss_in_if
// Input transaction channel: operation, item length and item index.
// ----------------------------------------------------------------------------
interface tlss_in_if;
  logic                         valid;
  logic                         ready;
  logic [tlss_pkg::OP_W-1:0]    op;
  logic [tlss_pkg::LEN_W-1:0]   item_length;
  logic [tlss_pkg::IDX_W-1:0]   item_index;

  modport source (output valid, op, item_length, item_index, input ready);
  modport sink   (input valid, op, item_length, item_index, output ready);
endinterface

### sv/tlss_out_if.sv
// ----------------------------------------------------------------------------
// tlss_out_if
// Result transaction channel: load status, item count and query answer.
// ----------------------------------------------------------------------------
interface tlss_out_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [tlss_pkg::CNT_W-1:0]   loaded_count;
  logic                         side;
  logic                         bad_index;

  modport source (output valid, accepted, loaded_count, side, bad_index, input ready);
  modport sink   (input valid, accepted, loaded_count, side, bad_index, output ready);
endinterface

### sv/tlss_ram.sv
// ----------------------------------------------------------------------------
// tlss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 129,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/tlss_reach.sv
// ----------------------------------------------------------------------------
// tlss_reach
// Double-buffered reachability store; reads past the lane end give zero and
// a freshly cleared store reads as the single lane-length bit.
// ----------------------------------------------------------------------------
module tlss_reach #(
  parameter int WORDS = 129,
  parameter int WAW   = 8,
  parameter int XAW   = 10
) (
  input  logic                          clk,
  input  tlss_pkg::reach_ctl_t          ctl,
  input  logic [XAW-1:0]                rd_addr,
  input  logic [WAW-1:0]                wr_addr,
  input  logic [tlss_pkg::WORD_W-1:0]   wr_data,
  input  logic [WAW-1:0]                lw,
  input  logic [tlss_pkg::BIT_W-1:0]    lbit,
  output logic [tlss_pkg::WORD_W-1:0]   rd_data
);

  logic [tlss_pkg::WORD_W-1:0] d0, d1;
  logic                        ok_r, isl_r, fresh_r, sel_r;
  logic [tlss_pkg::BIT_W-1:0]  lbit_r;

  // Write always goes to the buffer that is not being read.
  tlss_ram #(.WIDTH(tlss_pkg::WORD_W), .DEPTH(WORDS)) u_buf0 (
    .clk(clk), .we(ctl.wr_en && ctl.sel), .waddr(wr_addr), .wdata(wr_data),
    .raddr(WAW'(rd_addr)), .rdata(d0)
  );

  tlss_ram #(.WIDTH(tlss_pkg::WORD_W), .DEPTH(WORDS)) u_buf1 (
    .clk(clk), .we(ctl.wr_en && !ctl.sel), .waddr(wr_addr), .wdata(wr_data),
    .raddr(WAW'(rd_addr)), .rdata(d1)
  );

  always_ff @(posedge clk) begin
    ok_r    <= (rd_addr <= XAW'(lw));
    isl_r   <= (rd_addr == XAW'(lw));
    fresh_r <= ctl.fresh;
    sel_r   <= ctl.sel;
    lbit_r  <= lbit;
  end

  always_comb begin
    if (fresh_r) begin
      rd_data = isl_r ? (tlss_pkg::WORD_W'(1) << lbit_r) : '0;
    end else if (ok_r) begin
      rd_data = sel_r ? d1 : d0;
    end else begin
      rd_data = '0;
    end
  end

endmodule

### sv/tlss_word_unit.sv
// ----------------------------------------------------------------------------
// tlss_word_unit
// Shared word datapath: funnel shift of the reach words by the item length,
// room mask for the untracked lane, next reach word and choice word.
// ----------------------------------------------------------------------------
module tlss_word_unit #(
  parameter int SW  = 18,
  parameter int WAW = 8
) (
  input  logic [tlss_pkg::WORD_W-1:0]  lo,
  input  logic [tlss_pkg::WORD_W-1:0]  hi,
  input  logic [tlss_pkg::WORD_W-1:0]  cur,
  input  logic [tlss_pkg::BIT_W-1:0]   shift,
  input  logic signed [SW-1:0]         thr,
  input  logic [WAW-1:0]               w,
  input  logic                         zero_len,
  output logic [tlss_pkg::WORD_W-1:0]  next_word,
  output logic [tlss_pkg::WORD_W-1:0]  choice_word
);

  logic signed [SW-1:0]          diff;
  logic [tlss_pkg::BIT_W:0]      shamt;
  logic [tlss_pkg::WORD_W-1:0]   mask, unsh, shw;
  logic [2*tlss_pkg::WORD_W-1:0] cat;

  assign diff = thr - $signed(SW'({w, 6'b0}));

  // Bit b of this word may stay unshifted when w*64 + b <= thr.
  always_comb begin
    shamt = '0;
    if (diff < 0) begin
      mask = '0;
    end else if (diff >= $signed(SW'(63))) begin
      mask = '1;
    end else begin
      shamt = {1'b0, diff[5:0]} + 7'd1;
      mask  = ~({tlss_pkg::WORD_W{1'b1}} << shamt);
    end
  end

  assign cat  = {hi, lo} >> shift;
  assign shw  = cat[tlss_pkg::WORD_W-1:0];
  assign unsh = cur & mask;

  assign next_word   = shw | unsh;
  // The port path is recorded last, so it wins only for a zero-length item.
  assign choice_word = zero_len ? (shw & ~unsh) : shw;

endmodule

### sv/two_lane_subset_sum_loader.sv
// ----------------------------------------------------------------------------
// two_lane_subset_sum_loader
// Two-lane subset-sum loader with per-item choice bits and backtracking.
// ----------------------------------------------------------------------------
// Usage: in_chan carries one transaction per operation (clear, load item,
// finalize, query side); out_chan returns exactly one result transaction
// for each. cfg_we/cfg_wdata set the lane length and clear the loader.
// Flow: clear and rejected loads go straight to the push step; a load
// sweeps the reach words 0..L/64 through the shared word unit, reading
// the cur and hi words of each in turn (one reach buffer read port per
// access). Finalize scans the reach words for the lowest reachable word,
// then backtracks one loaded item at a time through the single
// choice-memory read port. A query reads the side memory; a query with a
// bad index goes straight to the push step.
// One operation is in flight at a time; in_chan.ready is high only when
// the sequencer is idle, also while a result still waits on out_chan.
// Reset: lane length 8192, loader empty; no memory clearing pass is
// needed, the cleared reach set is synthesized on read.
// Stall: a result is held in the output register until out_chan.ready;
// a finished operation waits in its push step behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_lane_subset_sum_loader #(
  parameter int LANE_MAX  = 8192,
  parameter int MAX_ITEMS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tlss_in_if.sink                     in_chan,
  tlss_out_if.source                  out_chan,
  input  logic                        cfg_we,
  input  logic [tlss_pkg::LEN_W-1:0]  cfg_wdata
);

  localparam int WORDS  = LANE_MAX / 64 + 1;
  localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XAW    = ((WAW > 8) ? WAW : 8) + 2;
  localparam int LW     = $clog2(LANE_MAX + 1);
  localparam int TW     = LW + 1;
  localparam int SW     = ((LW + 1 > tlss_pkg::LEN_W) ? LW + 1 : tlss_pkg::LEN_W) + 2;
  localparam int PW     = ((LW > tlss_pkg::LEN_W) ? LW : tlss_pkg::LEN_W) + 1;
  localparam int CW     = $clog2(MAX_ITEMS + 1);
  localparam int IAW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CDEPTH = MAX_ITEMS * WORDS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int SHW    = tlss_pkg::LEN_W - tlss_pkg::BIT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_INIT, S_LD_LO, S_LD_CUR, S_LD_HI, S_LD_END,
    S_FN_RD, S_FN_CHK, S_BT_RD, S_BT_CHK, S_QRY, S_PUSH
  } state_t;

  state_t                      state_r, state_nxt;
  logic [tlss_pkg::LEN_W-1:0]  lane_r, lane_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [TW-1:0]               total_r, total_nxt;
  logic                        stopped_r, stopped_nxt;
  logic                        final_r, final_nxt;
  logic                        fresh_r, fresh_nxt;
  logic                        sel_r, sel_nxt;
  logic [WAW-1:0]              w_r, w_nxt;
  logic [tlss_pkg::LEN_W-1:0]  n_r, n_nxt;
  logic signed [SW-1:0]        thr_r, thr_nxt;
  logic                        placed_r, placed_nxt;
  logic [tlss_pkg::WORD_W-1:0] lo_r, lo_nxt, cur_r, cur_nxt;
  logic [CAW-1:0]              row_r, row_nxt;
  logic [LW-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]               k_r, k_nxt;
  logic                        res_acc_r, res_acc_nxt, res_side_r, res_side_nxt;
  logic                        res_bad_r, res_bad_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_acc_r, out_acc_nxt, out_side_r, out_side_nxt;
  logic                        out_bad_r, out_bad_nxt;
  logic [tlss_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic [LW-1:0]               l_eff;
  logic [WAW-1:0]              lw;
  logic [SHW-1:0]              shw;
  tlss_pkg::op_t               op_in;
  tlss_pkg::reach_ctl_t        rctl;
  logic [XAW-1:0]              reach_addr;
  logic [tlss_pkg::WORD_W-1:0] reach_rd, next_word, choice_word, choice_rd;
  logic                        choice_we;
  logic [CAW-1:0]              choice_waddr, choice_raddr;
  logic                        len_we;
  logic [IAW-1:0]              len_raddr, side_waddr, side_raddr;
  logic [tlss_pkg::LEN_W-1:0]  len_rd;
  logic                        side_we, side_wdata, side_rd;
  logic                        found, bt_bit;
  logic [PW-1:0]               psum;
  logic [31:0]                 cnt32;

  // Effective lane length saturates at the build maximum.
  assign l_eff = (32'(lane_r) > LANE_MAX) ? LW'(LANE_MAX) : LW'(lane_r);
  assign lw    = WAW'(l_eff >> 6);
  assign shw   = SHW'(n_r >> 6);
  assign op_in = tlss_pkg::op_t'(in_chan.op);
  assign cnt32 = 32'(count_r);

  assign rctl.wr_en = (state_r == S_LD_HI);
  assign rctl.sel   = sel_r;
  assign rctl.fresh = fresh_r;

  tlss_reach #(.WORDS(WORDS), .WAW(WAW), .XAW(XAW)) u_reach (
    .clk(clk), .ctl(rctl), .rd_addr(reach_addr), .wr_addr(w_r),
    .wr_data(next_word), .lw(lw), .lbit(6'(l_eff)), .rd_data(reach_rd)
  );

  // Shared unit: one reach word per pass, hi word straight from the store.
  tlss_word_unit #(.SW(SW), .WAW(WAW)) u_word (
    .lo(lo_r), .hi(reach_rd), .cur(cur_r), .shift(n_r[5:0]), .thr(thr_r),
    .w(w_r), .zero_len(n_r == '0), .next_word(next_word), .choice_word(choice_word)
  );

  assign choice_we    = (state_r == S_LD_HI);
  assign choice_waddr = row_r + CAW'(w_r);
  assign choice_raddr = row_r + CAW'(pos_r >> 6);

  tlss_ram #(.WIDTH(tlss_pkg::WORD_W), .DEPTH(CDEPTH)) u_choice (
    .clk(clk), .we(choice_we), .waddr(choice_waddr), .wdata(choice_word),
    .raddr(choice_raddr), .rdata(choice_rd)
  );

  assign len_we    = (state_r == S_LD_END) && placed_r;
  assign len_raddr = IAW'(k_r - 1'b1);

  tlss_ram #(.WIDTH(tlss_pkg::LEN_W), .DEPTH(MAX_ITEMS)) u_len (
    .clk(clk), .we(len_we), .waddr(IAW'(count_r)), .wdata(n_r),
    .raddr(len_raddr), .rdata(len_rd)
  );

  assign side_we    = (state_r == S_BT_CHK);
  assign side_waddr = IAW'(k_r - 1'b1);
  assign side_wdata = bt_bit;
  assign side_raddr = IAW'(in_chan.item_index - 1'b1);

  tlss_ram #(.WIDTH(1), .DEPTH(MAX_ITEMS)) u_side (
    .clk(clk), .we(side_we), .waddr(side_waddr), .wdata(side_wdata),
    .raddr(side_raddr), .rdata(side_rd)
  );

  assign found  = |reach_rd;
  assign bt_bit = choice_rd[6'(pos_r)];
  assign psum   = PW'(pos_r) + (bt_bit ? PW'(len_rd) : PW'(0));

  // Reach read address for the access issued this cycle.
  always_comb begin
    case (state_r)
      S_LD_INIT: reach_addr = XAW'(shw);
      S_LD_LO:   reach_addr = XAW'(w_r);
      S_LD_CUR:  reach_addr = XAW'(w_r) + XAW'(shw) + XAW'(1);
      S_LD_HI:   reach_addr = XAW'(w_r) + XAW'(1);
      S_FN_RD:   reach_addr = XAW'(w_r);
      default:   reach_addr = '0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    lane_nxt     = lane_r;
    count_nxt    = count_r;
    total_nxt    = total_r;
    stopped_nxt  = stopped_r;
    final_nxt    = final_r;
    fresh_nxt    = fresh_r;
    sel_nxt      = sel_r;
    w_nxt        = w_r;
    n_nxt        = n_r;
    thr_nxt      = thr_r;
    placed_nxt   = placed_r;
    lo_nxt       = lo_r;
    cur_nxt      = cur_r;
    row_nxt      = row_r;
    pos_nxt      = pos_r;
    k_nxt        = k_r;
    res_acc_nxt  = res_acc_r;
    res_side_nxt = res_side_r;
    res_bad_nxt  = res_bad_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_acc_nxt  = out_acc_r;
    out_side_nxt = out_side_r;
    out_bad_nxt  = out_bad_r;
    out_cnt_nxt  = out_cnt_r;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          res_acc_nxt  = 1'b0;
          res_side_nxt = 1'b0;
          res_bad_nxt  = 1'b0;
          state_nxt    = S_PUSH;
          case (op_in)
            tlss_pkg::OP_CLEAR: begin
              count_nxt   = '0;
              total_nxt   = '0;
              stopped_nxt = 1'b0;
              final_nxt   = 1'b0;
              fresh_nxt   = 1'b1;
            end
            tlss_pkg::OP_LOAD: begin
              // Ignore loads once stopped or full.
              if (!stopped_r && (count_r != CW'(MAX_ITEMS))) begin
                n_nxt      = in_chan.item_length;
                thr_nxt    = $signed(SW'({l_eff, 1'b0})) - $signed(SW'(total_r))
                           - $signed(SW'(in_chan.item_length));
                row_nxt    = CAW'(cnt32 * WORDS);
                w_nxt      = '0;
                placed_nxt = 1'b0;
                state_nxt  = S_LD_INIT;
              end
            end
            tlss_pkg::OP_FINAL: begin
              w_nxt     = '0;
              state_nxt = S_FN_RD;
            end
            tlss_pkg::OP_QUERY: begin
              if (!final_r || (in_chan.item_index == '0) ||
                  (32'(in_chan.item_index) > cnt32) ||
                  (32'(in_chan.item_index) > MAX_ITEMS)) begin
                res_bad_nxt = 1'b1;
              end else begin
                state_nxt = S_QRY;
              end
            end
            default: ;
          endcase
        end
      end
      S_LD_INIT: state_nxt = S_LD_LO;
      S_LD_LO: begin
        lo_nxt    = reach_rd;
        state_nxt = S_LD_CUR;
      end
      S_LD_CUR: begin
        cur_nxt   = reach_rd;
        state_nxt = S_LD_HI;
      end
      S_LD_HI: begin
        // Advance the funnel: this hi word is the next word's lo word.
        lo_nxt     = reach_rd;
        placed_nxt = placed_r | (|next_word);
        if (w_r == lw) begin
          state_nxt = S_LD_END;
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = S_LD_CUR;
        end
      end
      S_LD_END: begin
        if (placed_r) begin
          sel_nxt     = ~sel_r;
          fresh_nxt   = 1'b0;
          count_nxt   = count_r + 1'b1;
          total_nxt   = total_r + TW'(n_r);
          final_nxt   = 1'b0;
          res_acc_nxt = 1'b1;
        end else begin
          stopped_nxt = 1'b1;
        end
        state_nxt = S_PUSH;
      end
      S_FN_RD: state_nxt = S_FN_CHK;
      S_FN_CHK: begin
        if (found || (w_r == lw)) begin
          pos_nxt = found ? LW'({w_r, tlss_pkg::lowest_set(reach_rd)}) : '0;
          if (count_r == '0) begin
            final_nxt = 1'b1;
            state_nxt = S_PUSH;
          end else begin
            k_nxt     = count_r;
            row_nxt   = CAW'(32'(count_r - 1'b1) * WORDS);
            state_nxt = S_BT_RD;
          end
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = S_FN_RD;
        end
      end
      S_BT_RD: state_nxt = S_BT_CHK;
      S_BT_CHK: begin
        pos_nxt = (psum > PW'(l_eff)) ? l_eff : LW'(psum);
        k_nxt   = k_r - 1'b1;
        row_nxt = row_r - CAW'(WORDS);
        if (k_r == CW'(1)) begin
          final_nxt = 1'b1;
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_BT_RD;
        end
      end
      S_QRY: begin
        res_side_nxt = side_rd;
        state_nxt    = S_PUSH;
      end
      S_PUSH: begin
        // Hold the result until the output register frees up.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = res_acc_r;
          out_side_nxt  = res_side_r;
          out_bad_nxt   = res_bad_r;
          out_cnt_nxt   = cnt32[tlss_pkg::CNT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A lane length write also clears the loader.
    if (cfg_we) begin
      lane_nxt    = cfg_wdata;
      count_nxt   = '0;
      total_nxt   = '0;
      stopped_nxt = 1'b0;
      final_nxt   = 1'b0;
      fresh_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lane_r      <= tlss_pkg::LEN_W'(8192);
      count_r     <= '0;
      total_r     <= '0;
      stopped_r   <= 1'b0;
      final_r     <= 1'b0;
      fresh_r     <= 1'b1;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane_r      <= lane_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      stopped_r   <= stopped_nxt;
      final_r     <= final_nxt;
      fresh_r     <= fresh_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
    w_r        <= w_nxt;
    n_r        <= n_nxt;
    thr_r      <= thr_nxt;
    placed_r   <= placed_nxt;
    lo_r       <= lo_nxt;
    cur_r      <= cur_nxt;
    row_r      <= row_nxt;
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    res_acc_r  <= res_acc_nxt;
    res_side_r <= res_side_nxt;
    res_bad_r  <= res_bad_nxt;
    out_acc_r  <= out_acc_nxt;
    out_side_r <= out_side_nxt;
    out_bad_r  <= out_bad_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.accepted     = out_acc_r;
  assign out_chan.loaded_count = out_cnt_r;
  assign out_chan.side         = out_side_r;
  assign out_chan.bad_index    = out_bad_r;

  `ASSERT_IMPL(a_count_bound, 1'b1, cnt32 <= MAX_ITEMS)
  `ASSERT_IMPL(a_sweep_bound, state_r == S_LD_HI, w_r <= lw)
  `ASSERT_NEXT(a_load_count, (state_r == S_LD_END) && placed_r && !cfg_we, count_r == CW'($past(count_r) + 1'b1))
  `ASSERT_NEXT(a_stop_hold, (state_r == S_LD_END) && !placed_r && !cfg_we, stopped_r && (count_r == $past(count_r)))

endmodule
